// ===== rtl/assert_macros.svh =====
// Assertion helpers: implication in the same cycle and in the next cycle.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/dsfp_pkg.sv =====
package dsfp_pkg;

    localparam int FRACTION_DIGITS = 8;
    localparam int MAX_CHARS       = 22;

    localparam int CHAR_CNT_W = 5;
    localparam int FRAC_CNT_W = $clog2(FRACTION_DIGITS + 1);

    localparam logic [63:0] POW10 [0:18] = '{
        64'd1,
        64'd10,
        64'd100,
        64'd1000,
        64'd10000,
        64'd100000,
        64'd1000000,
        64'd10000000,
        64'd100000000,
        64'd1000000000,
        64'd10000000000,
        64'd100000000000,
        64'd1000000000000,
        64'd10000000000000,
        64'd100000000000000,
        64'd1000000000000000,
        64'd10000000000000000,
        64'd100000000000000000,
        64'd1000000000000000000
    };

    localparam logic [63:0] SCALE        = POW10[FRACTION_DIGITS];
    localparam int          FRAC_W       = $clog2(SCALE);
    localparam logic [63:0] LIMIT        = 64'hFFFF_FFFF_FFFF_FFFF / SCALE;
    localparam logic [63:0] LIMIT_SCALED = LIMIT * SCALE;
    localparam logic [63:0] SENTINEL     = 64'hFFFF_F511_543F_B600;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_NEG  = 3'd1,
        ST_LONG = 3'd2,
        ST_BAD  = 3'd3,
        ST_OVF  = 3'd4,
        ST_SENT = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        TK_WHOLE,
        TK_FRAC,
        TK_SKIP,
        TK_NEG,
        TK_BAD
    } t_tok_cls;

    typedef struct packed {
        t_tok_cls                cls;
        logic [3:0]              digit;
        logic [FRAC_CNT_W-1:0]   frac_pos;
        logic                    too_long;
        logic                    last;
    } t_tok;

    // lowest nonzero code wins
    function automatic t_status err_merge(input t_status a, input t_status b);
        t_status r;
        if (a == ST_OK) begin
            r = b;
        end else if (b == ST_OK) begin
            r = a;
        end else begin
            r = (b < a) ? b : a;
        end
        return r;
    endfunction

    // weight of the fraction digit at a given position after the point
    function automatic logic [FRAC_W-1:0] frac_weight(input logic [FRAC_CNT_W-1:0] pos);
        logic [FRAC_W-1:0] w;
        w = '0;
        for (int k = 0; k < FRACTION_DIGITS; k++) begin
            if (pos == FRAC_CNT_W'(k)) begin
                w = FRAC_W'(POW10[FRACTION_DIGITS-1-k]);
            end
        end
        return w;
    endfunction

    // digit times the integer scale, as a small constant table
    function automatic logic [63:0] digit_scaled(input logic [3:0] d);
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < 10; k++) begin
            if (d == 4'(k)) begin
                v = 64'(SCALE * 64'(k));
            end
        end
        return v;
    endfunction

endpackage

// ===== rtl/dsfp_intf.sv =====
interface dsfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface dsfp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] amount;
    logic [2:0]  status;

    modport source (output valid, output amount, output status, input ready);
    modport sink   (input valid, input amount, input status, output ready);
endinterface

// ===== rtl/dsfp_front.sv =====
module dsfp_front
    import dsfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    dsfp_in_if.sink     i_in,
    input  logic        i_full,
    output logic        o_push,
    output t_tok        o_tok
);

    logic [CHAR_CNT_W-1:0] r_char_cnt, n_char_cnt;
    logic [FRAC_CNT_W-1:0] r_frac_cnt, n_frac_cnt;
    logic                  r_point, n_point;
    logic                  is_digit;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign is_digit   = (i_in.char_code >= CH_ZERO) && (i_in.char_code <= CH_NINE);

    always_comb begin
        o_tok.cls      = TK_BAD;
        o_tok.digit    = i_in.char_code[3:0];
        o_tok.frac_pos = r_frac_cnt;
        o_tok.too_long = (r_char_cnt >= CHAR_CNT_W'(MAX_CHARS));
        o_tok.last     = i_in.is_last;
        n_point        = r_point;
        n_frac_cnt     = r_frac_cnt;
        n_char_cnt     = (r_char_cnt != '1) ? r_char_cnt + 1'b1 : r_char_cnt;

        if (i_in.char_code == CH_MINUS && r_char_cnt == '0) begin
            o_tok.cls = TK_NEG;
        end else if (i_in.char_code == CH_POINT && !r_point) begin
            o_tok.cls = TK_SKIP;
            n_point   = 1'b1;
        end else if (is_digit) begin
            if (!r_point) begin
                o_tok.cls = TK_WHOLE;
            end else if (r_frac_cnt < FRAC_CNT_W'(FRACTION_DIGITS)) begin
                o_tok.cls  = TK_FRAC;
                n_frac_cnt = r_frac_cnt + 1'b1;
            end else begin
                // digits past the kept precision are dropped
                o_tok.cls = TK_SKIP;
            end
        end

        if (i_in.is_last) begin
            n_point    = 1'b0;
            n_frac_cnt = '0;
            n_char_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_cnt <= '0;
            r_frac_cnt <= '0;
            r_point    <= 1'b0;
        end else if (o_push) begin
            r_char_cnt <= n_char_cnt;
            r_frac_cnt <= n_frac_cnt;
            r_point    <= n_point;
        end
    end

endmodule

// ===== rtl/dsfp_fifo.sv =====
module dsfp_fifo
    import dsfp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_tok i_tok,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_tok o_tok
);

    t_tok                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/dsfp_back.sv =====
`include "assert_macros.svh"

module dsfp_back
    import dsfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_tok        i_q_tok,
    output logic        o_q_pop,
    dsfp_out_if.source  o_out
);

    // running integer part, kept already multiplied by the scale
    logic [63:0]       r_ws, n_ws;
    logic [FRAC_W-1:0] r_frac, n_frac;
    t_status           r_err, n_err;

    logic [67:0]       ws_step;
    logic              ws_ovf;

    logic              r_fin_valid;
    logic [63:0]       r_fin_ws;
    logic [FRAC_W-1:0] r_fin_frac;
    t_status           r_fin_err;
    logic              fin_move;
    logic              fin_free;

    logic [64:0]       total;
    t_status           fin_status;

    logic              r_out_valid;
    logic [63:0]       r_amount;
    t_status           r_status;

    assign fin_move = r_fin_valid && (!r_out_valid || o_out.ready);
    assign fin_free = !r_fin_valid || fin_move;
    assign o_q_pop  = i_q_valid && (!i_q_tok.last || fin_free);

    assign ws_step = ({4'b0, r_ws} << 3) + ({4'b0, r_ws} << 1)
                   + {4'b0, digit_scaled(i_q_tok.digit)};
    assign ws_ovf  = (ws_step > {4'b0, LIMIT_SCALED});

    always_comb begin
        n_ws   = r_ws;
        n_frac = r_frac;
        n_err  = r_err;
        if (i_q_tok.too_long) begin
            n_err = err_merge(n_err, ST_LONG);
        end
        case (i_q_tok.cls)
            TK_NEG:  n_err = err_merge(n_err, ST_NEG);
            TK_BAD:  n_err = err_merge(n_err, ST_BAD);
            TK_WHOLE: begin
                if (ws_ovf) begin
                    n_err = err_merge(n_err, ST_OVF);
                end else begin
                    n_ws = ws_step[63:0];
                end
            end
            TK_FRAC: n_frac = r_frac + FRAC_W'(i_q_tok.digit * frac_weight(i_q_tok.frac_pos));
            default: n_ws = r_ws;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws   <= '0;
            r_frac <= '0;
            r_err  <= ST_OK;
        end else if (o_q_pop) begin
            if (i_q_tok.last) begin
                r_ws   <= '0;
                r_frac <= '0;
                r_err  <= ST_OK;
            end else begin
                r_ws   <= n_ws;
                r_frac <= n_frac;
                r_err  <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (o_q_pop && i_q_tok.last) begin
            r_fin_valid <= 1'b1;
        end else if (fin_move) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_tok.last) begin
            r_fin_ws   <= n_ws;
            r_fin_frac <= n_frac;
            r_fin_err  <= n_err;
        end
    end

    assign total = {1'b0, r_fin_ws} + {{(65-FRAC_W){1'b0}}, r_fin_frac};

    always_comb begin
        fin_status = r_fin_err;
        if (r_fin_err == ST_OK) begin
            if (total >= {1'b0, 64'hFFFF_FFFF_FFFF_FFFF}) begin
                fin_status = ST_OVF;
            end else if (total[63:0] == SENTINEL) begin
                fin_status = ST_SENT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_move) begin
            r_amount <= (fin_status == ST_OK) ? total[63:0] : '0;
            r_status <= fin_status;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.amount = r_amount;
    assign o_out.status = r_status;

    `ASSERT_IMP(a_amount_zero_on_err, i_clk, i_rst_n, r_out_valid && r_status != ST_OK, r_amount == '0)
    `ASSERT_NXT(a_acc_clear_after_last, i_clk, i_rst_n, o_q_pop && i_q_tok.last, r_ws == '0 && r_frac == '0 && r_err == ST_OK)
    `ASSERT_NXT(a_fin_reaches_out, i_clk, i_rst_n, fin_move, r_out_valid)

endmodule

// ===== rtl/decimal_string_to_fixed_point_core.sv =====
// Decimal amount parser.
// Input channel i_in: one ASCII character per transfer (char_code), with
// is_last set on the final character of the amount string. Digits before an
// optional single '.' form the integer part; the first eight digits after it
// form the fraction, later ones are dropped, missing ones count as zero.
// Output channel o_out: one transfer per string, amount in 1e-8 units and a
// status (ok, negative, too long, bad character, overflow, sentinel). The
// amount is zero whenever the status is not ok.
// Throughput: one character per cycle while the queue is not full, including
// back-to-back strings; each character costs one multiply-by-ten and add in
// the accumulator stage.
// After its last character is transferred, the result for a string passes the
// queue, the accumulate stage, then the final add and range check.
// A four-entry queue separates the classifier from the accumulator, and an
// output register holds the result, so a stalled receiver only stops input
// once the queue fills. Reset is synchronous and clears all parser state; no
// result is pending afterward.
module decimal_string_to_fixed_point_core
    import dsfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    dsfp_in_if.sink     i_in,
    dsfp_out_if.source  o_out
);

    logic push;
    logic full;
    logic pop;
    logic q_valid;
    t_tok push_tok;
    t_tok q_tok;

    dsfp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_tok   (push_tok)
    );

    dsfp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (push_tok),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_tok   (q_tok)
    );

    dsfp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_tok   (q_tok),
        .o_q_pop   (pop),
        .o_out     (o_out)
    );

endmodule

// ===== tb/tb.sv =====
module tb
    import dsfp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_CHARS   = 1050;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_char_xfer;

    typedef struct packed {
        logic [63:0] amount;
        t_status     status;
    } t_amount_rec;

    logic clk = 1'b0;
    logic rst_n;

    dsfp_in_if  in_ch ();
    dsfp_out_if out_ch ();

    decimal_string_to_fixed_point_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    t_char_xfer  char_queue [$];
    t_amount_rec amounts_due [$];
    logic [7:0]  draft [$];

    int   chars_accepted = 0;
    int   fail_count     = 0;
    int   stall_cycles   = 0;
    logic quiet;

    // no random idling on either side during this window
    assign quiet = (chars_accepted >= 500) && (chars_accepted < 800);

    // parser state mirror
    logic [63:0] whole_part;
    logic [63:0] frac_part;
    int unsigned frac_taken;
    int unsigned chars_taken;
    bit          point_taken;
    t_status     err_held;

    function automatic void clear_parse();
        whole_part  = '0;
        frac_part   = '0;
        frac_taken  = 0;
        chars_taken = 0;
        point_taken = 1'b0;
        err_held    = ST_OK;
    endfunction

    // smallest nonzero code sticks
    function automatic void raise_error(t_status e);
        if (err_held == ST_OK || e < err_held) begin
            err_held = e;
        end
    endfunction

    function automatic bit parse_char(input logic [7:0] c, input logic last,
                                      output logic [63:0] amt, output t_status st);
        logic [63:0] grown;
        logic [63:0] frac_full;
        logic [63:0] base;
        logic [63:0] total;
        logic [3:0]  d;
        amt = '0;
        st  = ST_OK;
        if (chars_taken >= MAX_CHARS) begin
            raise_error(ST_LONG);
        end
        if (c == CH_MINUS && chars_taken == 0) begin
            raise_error(ST_NEG);
        end else if (c == CH_POINT && !point_taken) begin
            point_taken = 1'b1;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 4'(c - CH_ZERO);
            if (point_taken) begin
                if (frac_taken < FRACTION_DIGITS) begin
                    frac_part = frac_part * 64'd10 + 64'(d);
                    frac_taken++;
                end
            end else if (whole_part <= LIMIT) begin
                grown = whole_part * 64'd10 + 64'(d);
                if (grown > LIMIT) begin
                    raise_error(ST_OVF);
                end else begin
                    whole_part = grown;
                end
            end else begin
                raise_error(ST_OVF);
            end
        end else begin
            raise_error(ST_BAD);
        end
        if (chars_taken < 31) begin
            chars_taken++;
        end
        if (!last) begin
            return 1'b0;
        end
        frac_full = frac_part;
        for (int k = frac_taken; k < FRACTION_DIGITS; k++) begin
            frac_full = frac_full * 64'd10;
        end
        total = '0;
        if (whole_part > LIMIT) begin
            raise_error(ST_OVF);
        end
        if (err_held == ST_OK) begin
            base = whole_part * SCALE;
            // the all-ones value is out of range too
            if (frac_full >= 64'hFFFF_FFFF_FFFF_FFFF - base) begin
                raise_error(ST_OVF);
            end else begin
                total = base + frac_full;
            end
        end
        if (err_held == ST_OK && total == SENTINEL) begin
            raise_error(ST_SENT);
        end
        amt = (err_held == ST_OK) ? total : 64'd0;
        st  = err_held;
        clear_parse();
        return 1'b1;
    endfunction

    // stimulus building
    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic void append_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            draft.push_back(s[i]);
        end
    endfunction

    function automatic void flush_draft();
        t_char_xfer x;
        for (int i = 0; i < draft.size(); i++) begin
            x.code = draft[i];
            x.last = (i == draft.size() - 1);
            char_queue.push_back(x);
        end
        draft.delete();
    endfunction

    function automatic void send_text(string s);
        append_text(s);
        flush_draft();
    endfunction

    // well-formed number: integer digits, optional point and fraction
    function automatic void append_number();
        int sel;
        int n;
        sel = $urandom_range(9);
        if (sel == 0) begin
            case ($urandom_range(3))
                0: append_text("184467440737");
                1: append_text("18446744073");
                2: append_text("184467320535");
                default: append_text("184467440738");
            endcase
            // land right at the top of the range or on the sentinel
            if ($urandom_range(1) == 0) begin
                append_text(".0955161");
                draft.push_back(rand_digit());
                return;
            end
        end else begin
            n = ($urandom_range(7) == 0) ? $urandom_range(7, 13) : $urandom_range(0, 6);
            repeat (n) draft.push_back(rand_digit());
        end
        if ($urandom_range(3) != 0) begin
            draft.push_back(CH_POINT);
            n = $urandom_range(0, 10);
            repeat (n) draft.push_back(rand_digit());
        end
        if (draft.size() == 0) begin
            draft.push_back(rand_digit());
        end
    endfunction

    function automatic void add_random_amount();
        int kind;
        int n;
        int pos;
        kind = $urandom_range(99);
        draft.delete();
        if (kind >= 94) begin
            n = $urandom_range(1, 6);
            repeat (n) draft.push_back(8'($urandom_range(255)));
        end else if (kind >= 88) begin
            n = $urandom_range(20, 34);
            repeat (n) draft.push_back(($urandom_range(9) == 0) ? CH_POINT : rand_digit());
        end else begin
            if (kind >= 80) begin
                draft.push_back(CH_MINUS);
            end
            append_number();
            if (kind >= 70 && kind < 80) begin
                pos = $urandom_range(draft.size() - 1);
                draft[pos] = 8'($urandom_range(255));
            end
        end
        flush_draft();
    endfunction

    // driver: one transfer per cycle at most, prediction on acceptance
    always @(posedge clk) begin : drive_chars
        t_char_xfer  nxt;
        logic [63:0] amt;
        t_status     st;
        bit          got;
        if (!rst_n) begin
            in_ch.valid     <= 1'b0;
            in_ch.char_code <= '0;
            in_ch.is_last   <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                chars_accepted <= chars_accepted + 1;
                got = parse_char(in_ch.char_code, in_ch.is_last, amt, st);
                if (got) begin
                    amounts_due.push_back(t_amount_rec'{amt, st});
                end
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (char_queue.size() != 0 && (quiet || $urandom_range(99) >= 8)) begin
                    nxt = char_queue.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.char_code <= nxt.code;
                    in_ch.is_last   <= nxt.last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge clk) begin : check_results
        t_amount_rec want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (amounts_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got amount %0d status %0d",
                             $time, out_ch.amount, out_ch.status);
                    fail_count++;
                end else begin
                    want = amounts_due.pop_front();
                    if (out_ch.amount !== want.amount) begin
                        $display("%0t: amount mismatch, expected %0d, got %0d",
                                 $time, want.amount, out_ch.amount);
                        fail_count++;
                    end
                    if (out_ch.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, out_ch.status);
                        fail_count++;
                    end
                end
            end
            out_ch.ready <= quiet || ($urandom_range(99) >= 8);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n) begin
            stall_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
            $display("** decimal_string_to_fixed_point_core: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int base_count;
        rst_n <= 1'b0;
        clear_parse();

        // directed strings
        send_text("0");
        send_text("9");
        send_text("-5");
        send_text("5-");
        send_text("1.2.3");
        send_text(".5");
        send_text("5.");
        send_text(".");
        send_text("-");
        send_text("12a");
        send_text("0000000000000000000001");
        send_text("00000000000000000000001");
        send_text("1234567890123456789012345678901234567890");
        send_text("184467440737.09551614");
        send_text("184467440737.09551615");
        send_text("184467440738");
        send_text("1844674407370");
        send_text("184467320535.09551616");
        send_text("1.123456789");
        send_text("1.12345678x");
        send_text("0.00000001");
        send_text("-.x");
        send_text("-00000000000000000000000x");
        draft.push_back(8'h00);
        flush_draft();
        draft.push_back(8'hFF);
        flush_draft();

        base_count = char_queue.size();
        while (char_queue.size() < base_count + RANDOM_CHARS) begin
            add_random_amount();
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (char_queue.size() != 0 || in_ch.valid) begin
            @(posedge clk);
        end
        while (amounts_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("** decimal_string_to_fixed_point_core: PASSED **");
        end else begin
            $display("** decimal_string_to_fixed_point_core: FAILED **");
        end
        $finish;
    end

endmodule
